// ===== rtl/adr_pkg.sv =====
// Shared types and constants for the allele dictionary recoder.
package adr_pkg;

   localparam int MAX_ALLELES = 64;
   localparam int IDX_W       = $clog2(MAX_ALLELES);
   localparam int CNT_W       = 7;
   localparam int VAL_W       = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic signed [VAL_W-1:0] NULL_ALLELE     = 16'sd29697;
   localparam logic signed [VAL_W-1:0] DEFAULT_MISSING = -16'sd9;
   localparam logic signed [VAL_W-1:0] RESET_UNAMBIG   = -16'sd999;

   localparam logic KIND_ALLELE  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] CSR_MISSING_CODE     = 2'd0;
   localparam logic [1:0] CSR_UNAMBIGUOUS_CODE = 2'd1;
   localparam logic [1:0] CSR_RECESSIVE_ON     = 2'd2;

   typedef struct packed {
      logic signed [VAL_W-1:0] allele_value;
      logic                    first_of_locus;
      logic                    last_of_locus;
      logic signed [VAL_W-1:0] recessive_value;
   } req_type;

   typedef struct packed {
      logic                    kind;
      logic signed [VAL_W-1:0] code;
      logic                    new_entry;
      logic [CNT_W-1:0]        allele_count;
      logic signed [VAL_W-1:0] recessive_code;
      logic                    null_added;
      logic                    overflow;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] missing_code;
      logic signed [VAL_W-1:0] unambiguous_code;
      logic                    recessive_on;
   } cfg_type;

   // queue entry: the transaction plus its classification
   typedef struct packed {
      req_type req;
      logic    is_missing;
   } work_type;

endpackage

// ===== rtl/adr_front.sv =====
// Front end: accepts input transactions, classifies them and queues them.
module adr_front
   import adr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     q_valid,
   output work_type q_data,
   input  logic     q_pop
);

   work_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              push;
   logic              pop;
   work_type          entry;

   assign req_stall = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      entry.req        = req_data;
      entry.is_missing = (req_data.allele_value == cfg.missing_code);
      wr_ptr_in        = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in        = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in          = fill_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ===== rtl/adr_back.sv =====
// Back end: dictionary lookup and insert, recessive tracking, locus summary.
module adr_back
   import adr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_valid,
   input  work_type q_data,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   typedef enum logic [1:0] {
      BK_ALLELE  = 2'b01,
      BK_SUMMARY = 2'b10
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic signed [VAL_W-1:0] table_ff [MAX_ALLELES];
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [VAL_W-1:0] target_ff, target_in;
   logic [IDX_W-1:0]        rindex_ff, rindex_in;
   logic                    seen_ff, seen_in;
   logic                    ovf_ff, ovf_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    out_free;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic signed [VAL_W-1:0] wr_val;
   logic signed [VAL_W-1:0] nm, nu;
   logic [CNT_W-1:0]        eff_count;
   logic                    eff_ovf, eff_seen;
   logic [IDX_W-1:0]        eff_index;
   logic signed [VAL_W-1:0] eff_target;
   logic [MAX_ALLELES-1:0]  hit;
   logic [IDX_W-1:0]        hit_pos;
   logic                    table_full;
   logic                    rec_real;
   logic signed [VAL_W-1:0] val;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == BK_ALLELE) && out_free && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign val       = q_data.req.allele_value;

   // new missing code: a non-negative configured code up to MAX_ALLELES, which could collide with an index, maps to -9
   assign nm = (!cfg.missing_code[VAL_W-1] &&
                cfg.missing_code <= $signed(VAL_W'(MAX_ALLELES))) ?
               DEFAULT_MISSING : cfg.missing_code;
   assign nu = nm - 16'sd1;

   always_comb begin
      eff_count  = q_data.req.first_of_locus ? '0   : count_ff;
      eff_ovf    = q_data.req.first_of_locus ? 1'b0 : ovf_ff;
      eff_seen   = q_data.req.first_of_locus ? 1'b0 : seen_ff;
      eff_index  = q_data.req.first_of_locus ? '0   : rindex_ff;
      eff_target = q_data.req.first_of_locus ? q_data.req.recessive_value : target_ff;
      table_full = (eff_count >= CNT_W'(MAX_ALLELES));
      rec_real   = cfg.recessive_on && (eff_target != cfg.missing_code) &&
                   (eff_target != cfg.unambiguous_code);
      for (int i = 0; i < MAX_ALLELES; i++) begin
         hit[i] = (CNT_W'(i) < eff_count) && (table_ff[i] == val);
      end
      // lowest matching slot wins; the null allele may duplicate a real value
      hit_pos = '0;
      for (int i = MAX_ALLELES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_pos = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      target_in    = target_ff;
      rindex_in    = rindex_ff;
      seen_in      = seen_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_val       = val;

      case (state_ff)
         BK_ALLELE: begin
            if (q_pop) begin
               count_in  = eff_count;
               target_in = eff_target;
               rindex_in = eff_index;
               seen_in   = eff_seen;
               ovf_in    = eff_ovf;
               rsp_in    = '0;
               rsp_in.kind = KIND_ALLELE;
               if (q_data.is_missing) begin
                  rsp_in.code = nm;
               end else if (|hit) begin
                  rsp_in.code = {{(VAL_W-IDX_W){1'b0}}, hit_pos};
               end else if (table_full) begin
                  ovf_in      = 1'b1;
                  rsp_in.code = nm;
               end else begin
                  wr_en            = 1'b1;
                  wr_addr          = eff_count[IDX_W-1:0];
                  rsp_in.code      = {{(VAL_W-IDX_W){1'b0}}, eff_count[IDX_W-1:0]};
                  rsp_in.new_entry = 1'b1;
                  count_in         = eff_count + 1'b1;
                  if (rec_real && !eff_seen && (val == eff_target)) begin
                     seen_in   = 1'b1;
                     rindex_in = eff_count[IDX_W-1:0];
                  end
               end
               rsp_in.overflow = ovf_in;
               rsp_in.last     = !q_data.req.last_of_locus;
               rsp_valid_in    = 1'b1;
               if (q_data.req.last_of_locus) begin
                  state_in = BK_SUMMARY;
               end
            end
         end
         BK_SUMMARY: begin
            if (out_free) begin
               rsp_in      = '0;
               rsp_in.kind = KIND_SUMMARY;
               if (!cfg.recessive_on) begin
                  rsp_in.recessive_code = '0;
               end else if (target_ff == cfg.missing_code) begin
                  rsp_in.recessive_code = nm;
               end else if (target_ff == cfg.unambiguous_code) begin
                  rsp_in.recessive_code = nu;
               end else if (seen_ff) begin
                  rsp_in.recessive_code = {{(VAL_W-IDX_W){1'b0}}, rindex_ff};
               end else if (count_ff == '0) begin
                  rsp_in.recessive_code = nm;
               end else if (count_ff >= CNT_W'(MAX_ALLELES)) begin
                  ovf_in                = 1'b1;
                  rsp_in.recessive_code = nm;
               end else begin
                  wr_en                 = 1'b1;
                  wr_val                = NULL_ALLELE;
                  rsp_in.recessive_code = {{(VAL_W-IDX_W){1'b0}}, count_ff[IDX_W-1:0]};
                  rsp_in.null_added     = 1'b1;
                  count_in              = count_ff + 1'b1;
               end
               rsp_in.allele_count = count_in;
               rsp_in.overflow     = ovf_in;
               rsp_in.last         = 1'b1;
               rsp_valid_in        = 1'b1;
               state_in            = BK_ALLELE;
            end
         end
         default: begin
            state_in = BK_ALLELE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_ALLELE;
         count_ff     <= '0;
         target_ff    <= '0;
         rindex_ff    <= '0;
         seen_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         target_ff    <= target_in;
         rindex_ff    <= rindex_in;
         seen_ff      <= seen_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (wr_en) begin
         table_ff[wr_addr] <= wr_val;
      end
   end

endmodule

// ===== rtl/allele_dictionary_recoder.sv =====
// Allele dictionary recoder: an accepted transaction is queued in the front end, then
// registered in the back end's output register. Throughput: one transaction per cycle while
// no stall holds it; a locus end adds its summary in a separate back-end summary state.
// Reset: synchronous; clears queue, counters, flags and output valid, loads the register
// reset values. The value table is not cleared: entries at or above the count are never read.
module allele_dictionary_recoder
   import adr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input transactions
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   // result transactions
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [VAL_W-1:0]        csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     q_valid;
   logic     q_pop;
   work_type q_data;

   // Register writes are always taken; an index past the list is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MISSING_CODE:     cfg_in.missing_code     = csr_data;
            CSR_UNAMBIGUOUS_CODE: cfg_in.unambiguous_code = csr_data;
            CSR_RECESSIVE_ON:     cfg_in.recessive_on     = csr_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.missing_code     <= DEFAULT_MISSING;
         cfg_ff.unambiguous_code <= RESET_UNAMBIG;
         cfg_ff.recessive_on     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: take transactions, tag missing values, buffer them.
   adr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   // Back: lookup/insert against the table, then the locus summary when flagged.
   adr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Output register comes up empty after reset.
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A summary always closes the results of its locus.
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_SUMMARY) |-> rsp_data.last)
      else $error("summary not flagged last");

   // Allele count never passes table capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_SUMMARY) |->
      (rsp_data.allele_count <= CNT_W'(MAX_ALLELES)))
      else $error("allele count beyond capacity");

   // A new table entry only comes with an allele result carrying a table index.
   a_new_entry_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.new_entry) |->
      (rsp_data.kind == KIND_ALLELE && !rsp_data.code[VAL_W-1]))
      else $error("new entry with non-index code");

endmodule
